[hdl/brlf_pkg.sv]
// ----------------------------------------------------------------------------
// brlf_pkg
// Shared types, codes and constants of the byte ring buffer line finder.
// ----------------------------------------------------------------------------
package brlf_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int MAX_SEP      = 4;
    localparam int SEPN_W       = $clog2(MAX_SEP + 1);

    localparam int ACT_W       = 2;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 11;
    localparam int ST_W        = 2;
    localparam int SEP_LEN_W   = 3;
    localparam int SEP_BYTES_W = 32;
    localparam int CFG_IDX_W   = 1;

    // action codes
    localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FIND = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SKIP = 2'd3;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_SHORT    = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_LEN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_BYTES = 1'd1;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  count;
    } t_item;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [BYTE_W-1:0] out_byte;
        logic [LEN_W-1:0]  line_length;
        logic [LEN_W-1:0]  fill_level;
    } t_result;

    typedef struct packed {
        logic              shift;
        logic [BYTE_W-1:0] din;
    } t_match_ctl;

    // separator byte k; bytes past the fourth read as zero
    function automatic logic [BYTE_W-1:0] f_sep_byte(input logic [SEP_BYTES_W-1:0] sep,
                                                     input int k);
        logic [BYTE_W-1:0] b;
        b = '0;
        if (k >= 0 && k < SEP_BYTES_W / BYTE_W) begin
            b = sep[BYTE_W*k +: BYTE_W];
        end
        return b;
    endfunction

endpackage

[hdl/brlf_ram.sv]
// ----------------------------------------------------------------------------
// brlf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/brlf_match.sv]
// ----------------------------------------------------------------------------
// brlf_match
// Separator window: shifts in one stored byte per beat and compares the
// newest bytes against the separator.
// ----------------------------------------------------------------------------
module brlf_match import brlf_pkg::*; (
    input  logic                   i_clk,
    input  t_match_ctl             i_ctl,
    input  logic [SEP_BYTES_W-1:0] i_sep_bytes,
    input  logic [SEPN_W-1:0]      i_sep_n,
    output logic                   o_hit
);

    localparam int WIN = (MAX_SEP > 1) ? MAX_SEP - 1 : 1;

    // r_win[0] is the byte before the newest one
    logic [BYTE_W-1:0] r_win [WIN];
    logic [BYTE_W-1:0] nw    [MAX_SEP];

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_win[0] <= i_ctl.din;
            for (int m = 1; m < WIN; m++) begin
                r_win[m] <= r_win[m-1];
            end
        end
    end

    // nw[m] is the byte m places before the incoming one; it must equal
    // separator byte n-1-m
    always_comb begin
        nw[0] = i_ctl.din;
        for (int m = 1; m < MAX_SEP; m++) begin
            nw[m] = r_win[m-1];
        end
        o_hit = 1'b1;
        for (int m = 0; m < MAX_SEP; m++) begin
            if (m < int'(i_sep_n)) begin
                if (nw[m] != f_sep_byte(i_sep_bytes, int'(i_sep_n) - 1 - m)) begin
                    o_hit = 1'b0;
                end
            end
        end
    end

endmodule

[hdl/brlf_ctrl.sv]
// ----------------------------------------------------------------------------
// brlf_ctrl
// Sequencer of the ring: head, tail and level, the byte store, and the
// line scan that feeds stored bytes to the separator window.
// ----------------------------------------------------------------------------
module brlf_ctrl import brlf_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_item                           i_item,
    input  logic                            i_item_valid,
    output logic                            o_item_ready,
    input  logic [SEPN_W-1:0]               i_sep_n,
    output t_match_ctl                      o_match,
    input  logic                            i_match_hit,
    output t_result                         o_res,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output logic [$clog2(CAPACITY+1)-1:0]   o_level
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int LVL_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = LVL_W + 1;
    localparam int CMP_W = (LVL_W > LEN_W) ? LVL_W : LEN_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_POPW = 3'd2;
    localparam logic [2:0] S_FIND = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    logic [2:0]       r_state, n_state;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [LVL_W-1:0] r_level, n_level;
    t_item            r_item, n_item;
    t_result          r_res, n_res;
    logic [PTR_W-1:0] r_scan, n_scan;
    logic [LVL_W-1:0] r_rd_cnt, n_rd_cnt;
    logic [LVL_W-1:0] r_seen, n_seen;
    logic             r_rd_pend, n_rd_pend;

    logic             ram_we;
    logic             ram_re;
    logic [PTR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_q;

    logic [LVL_W-1:0] sep_n;
    logic [LVL_W-1:0] skip_n;
    logic [SUM_W-1:0] head_sum;
    logic [SUM_W-1:0] head_wrap;
    logic [LVL_W-1:0] seen_nx;

    brlf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (r_item.data_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign sep_n     = LVL_W'(i_sep_n);
    assign skip_n    = (r_item.count == '0) ? r_level : LVL_W'(r_item.count);
    assign head_sum  = SUM_W'(r_head) + SUM_W'(skip_n);
    assign head_wrap = (head_sum >= SUM_W'(CAPACITY)) ? head_sum - SUM_W'(CAPACITY) : head_sum;
    assign seen_nx   = r_seen + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_level   = r_level;
        n_item    = r_item;
        n_res     = r_res;
        n_scan    = r_scan;
        n_rd_cnt  = r_rd_cnt;
        n_seen    = r_seen;
        n_rd_pend = r_rd_pend;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_head;
        o_match.shift = 1'b0;
        o_match.din   = ram_q;

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_item  = i_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res   = '0;
                n_state = S_DONE;
                unique case (r_item.action)
                    ACT_PUSH: begin
                        if (r_level >= LVL_W'(CAPACITY)) begin
                            n_res.status = ST_FULL;
                        end else begin
                            ram_we  = 1'b1;
                            n_tail  = f_inc(r_tail);
                            n_level = r_level + 1'b1;
                        end
                    end
                    ACT_POP: begin
                        if (r_level == '0) begin
                            n_res.status = ST_SHORT;
                        end else begin
                            ram_re  = 1'b1;
                            n_state = S_POPW;
                        end
                    end
                    ACT_FIND: begin
                        if (r_level < sep_n) begin
                            n_res.status = ST_NOTFOUND;
                        end else begin
                            n_scan    = r_head;
                            n_rd_cnt  = '0;
                            n_seen    = '0;
                            n_rd_pend = 1'b0;
                            n_state   = S_FIND;
                        end
                    end
                    ACT_SKIP: begin
                        if (r_level == '0 || CMP_W'(r_item.count) > CMP_W'(r_level)) begin
                            n_res.status = ST_SHORT;
                        end else begin
                            n_head  = PTR_W'(head_wrap);
                            n_level = r_level - skip_n;
                            if (r_level == skip_n) begin
                                n_head = '0;
                                n_tail = '0;
                            end
                        end
                    end
                endcase
            end
            S_POPW: begin
                n_res.out_byte = ram_q;
                n_head  = f_inc(r_head);
                n_level = r_level - 1'b1;
                if (r_level == LVL_W'(1)) begin
                    n_head = '0;
                    n_tail = '0;
                end
                n_state = S_DONE;
            end
            S_FIND: begin
                // one read issued and one byte compared per beat
                n_rd_pend = 1'b0;
                if (r_rd_cnt != r_level) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_scan;
                    n_scan    = f_inc(r_scan);
                    n_rd_cnt  = r_rd_cnt + 1'b1;
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend) begin
                    o_match.shift = 1'b1;
                    n_seen        = seen_nx;
                    if (i_match_hit && seen_nx >= sep_n) begin
                        n_res.line_length = LEN_W'(seen_nx - sep_n);
                        n_state           = S_DONE;
                    end else if (seen_nx == r_level) begin
                        n_res.status = ST_NOTFOUND;
                        n_state      = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_tail    <= '0;
            r_level   <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_level   <= n_level;
            r_rd_pend <= n_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_res    <= n_res;
        r_scan   <= n_scan;
        r_rd_cnt <= n_rd_cnt;
        r_seen   <= n_seen;
    end

    always_comb begin
        o_res            = r_res;
        o_res.fill_level = LEN_W'(r_level);
    end

    assign o_res_valid  = (r_state == S_DONE);
    assign o_item_ready = (r_state == S_IDLE);
    assign o_level      = r_level;

endmodule

[hdl/byte_ring_buffer_line_finder.sv]
// ----------------------------------------------------------------------------
// byte_ring_buffer_line_finder
// Circular byte store with push, pop, skip and separator search.
//
//   channel   dir  beat fields
//   s_axis    in   tuser: action; tdata: data_byte, count
//   m_axis    out  tuser: status; tdata: out_byte, line_length, fill_level
//   cfg       in   i_cfg_we / i_cfg_idx / i_cfg_wdata (sep_len, sep_bytes)
//
// Push and skip go from accept through EXEC to their result in DONE; pop
// adds POPW (one RAM read). Find line scans in FIND: the single RAM read port
// feeds one stored byte per cycle into the separator window compare.
// Reset is synchronous; after it the store is empty and usable at once.
// A finished result sits in the output register while the next item is
// accepted; the sequencer waits only while that register is full and m_axis_tready is low.
// ----------------------------------------------------------------------------
module byte_ring_buffer_line_finder import brlf_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [23:0]            s_axis_tdata,   // data_byte[7:0], count[18:8]
    input  logic [1:0]             s_axis_tuser,   // action[1:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [31:0]            m_axis_tdata,   // out_byte[7:0], line_length[18:8],
                                                   // fill_level[29:19]
    output logic [1:0]             m_axis_tuser,   // status[1:0]
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [SEP_BYTES_W-1:0] i_cfg_wdata
);

    localparam int LVL_W = $clog2(CAPACITY + 1);

    logic [SEP_LEN_W-1:0]   r_sep_len;
    logic [SEP_BYTES_W-1:0] r_sep_bytes;
    logic [SEPN_W-1:0]      sep_n;

    t_item      item;
    t_result    res;
    logic       res_valid;
    logic       res_ready;
    t_match_ctl match_ctl;
    logic       match_hit;
    logic [LVL_W-1:0] level;

    logic    r_out_valid;
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_len   <= SEP_LEN_W'(1);
            r_sep_bytes <= SEP_BYTES_W'(10);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEP_LEN:   r_sep_len   <= i_cfg_wdata[SEP_LEN_W-1:0];
                CFG_SEP_BYTES: r_sep_bytes <= i_cfg_wdata;
            endcase
        end
    end

    // zero length means one, anything past the window saturates
    always_comb begin
        if (r_sep_len == '0) begin
            sep_n = SEPN_W'(1);
        end else if (int'(r_sep_len) > MAX_SEP) begin
            sep_n = SEPN_W'(MAX_SEP);
        end else begin
            sep_n = SEPN_W'(r_sep_len);
        end
    end

    assign item.action    = s_axis_tuser;
    assign item.data_byte = s_axis_tdata[7:0];
    assign item.count     = s_axis_tdata[18:8];

    brlf_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (item),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (s_axis_tready),
        .i_sep_n      (sep_n),
        .o_match      (match_ctl),
        .i_match_hit  (match_hit),
        .o_res        (res),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_level      (level)
    );

    brlf_match u_match (
        .i_clk       (i_clk),
        .i_ctl       (match_ctl),
        .i_sep_bytes (r_sep_bytes),
        .i_sep_n     (sep_n),
        .o_hit       (match_hit)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {2'b00, r_out.fill_level, r_out.line_length, r_out.out_byte};

    // the sequencer takes one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while a previous one is in work");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= LVL_W'(CAPACITY))
        else $error("fill level above capacity");

    a_fail_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out.status != ST_OK |->
            r_out.out_byte == '0 && r_out.line_length == '0)
        else $error("failed beat carries payload");

    a_full_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out.status == ST_FULL |-> r_out.fill_level == LEN_W'(CAPACITY))
        else $error("full reported below capacity");

endmodule
